### src/grht_pkg.sv
// Package for the generational handle table with reference counts.
// Holds table sizes, field widths, request and status codes and the slot entry type.
// No dependencies.
package grht_pkg;

    localparam int SLOTS   = 1024;
    localparam int IW      = $clog2(SLOTS);
    localparam int CW      = $clog2(SLOTS + 1);
    localparam int TOK_W   = 64;
    localparam int GEN_W   = 32;
    localparam int REF_W   = 32;
    localparam int ENTRY_W = TOK_W + GEN_W + REF_W;

    localparam logic [REF_W-1:0] REFS_MAX = {REF_W{1'b1}};
    localparam logic [GEN_W-1:0] GEN_MAX  = {GEN_W{1'b1}};
    localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);

    localparam logic [1:0] REQ_WRAP    = 2'd0;
    localparam logic [1:0] REQ_ACQUIRE = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_INVALID_PARAM = 3'd1;
    localparam logic [2:0] ST_NO_RESOURCES  = 3'd2;
    localparam logic [2:0] ST_INVALID_STATE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW      = 3'd4;

    // One slot as it sits in the table memory. Only the generation of the
    // handle is stored; the index part is the slot address itself.
    typedef struct packed {
        logic [TOK_W-1:0] tok;
        logic [GEN_W-1:0] gen;
        logic [REF_W-1:0] refs;
    } t_entry;

endpackage

### src/generational_refcount_handle_table_unit.sv
// Top level of the generational handle table with reference counts.
// Depends on grht_pkg and on grht_ram for the slot table.
//
// Usage. One input channel (i_valid / o_stall) carries requests: wrap a token,
// acquire a handle or release a handle. One output channel (o_valid / i_stall)
// returns exactly one result transaction per request, in request order.
// A transaction moves at a rising edge where valid is high and stall is low.
// Operation. All slots live in one memory with a registered read port, and a
// small sequencer drives that port. Acquire and release read the slot, check
// it and write it back. A wrap sweeps every slot through the read port, one per
// cycle, to find a duplicate token and the lowest free slot. Requests rejected
// on their fields alone go straight to the result stage without a table access.
// Flow. One request is in flight at a time: the next is taken the cycle after a
// result is loaded.
// Reset. After i_rst_n is released, a clearing pass writes zero to every slot,
// one per cycle; o_stall stays high meanwhile.
// Stall. A result waits in the output register as long as i_stall is high.
// A finished request whose result cannot yet be loaded waits in its own hold
// register, and the block takes no new request until that result is loaded.
module generational_refcount_handle_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_handle_in,
    input  logic [63:0] i_data_token,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_handle_out,
    output logic [63:0] o_data_out,
    output logic        o_freed
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_WFIN  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Sequencer registers.
    logic [grht_pkg::CW-1:0]    r_addr, n_addr;
    logic                       r_rd_v, n_rd_v;
    logic [grht_pkg::IW-1:0]    r_rd_idx, n_rd_idx;
    logic [1:0]                 r_req, n_req;
    logic [grht_pkg::GEN_W-1:0] r_h, n_h;
    logic [63:0]                r_tok, n_tok;
    logic [grht_pkg::IW-1:0]    r_idx, n_idx;
    logic                       r_dup, n_dup;
    logic                       r_found, n_found;
    logic [grht_pkg::GEN_W-1:0] r_gen, n_gen;

    // Result hold registers.
    logic [2:0]  r_res_status, n_res_status;
    logic [63:0] r_res_handle, n_res_handle;
    logic [63:0] r_res_data, n_res_data;
    logic        r_res_freed, n_res_freed;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_out_status, n_out_status;
    logic [63:0] r_out_handle, n_out_handle;
    logic [63:0] r_out_data, n_out_data;
    logic        r_out_freed, n_out_freed;

    // Table memory port signals.
    logic                    ram_we;
    logic [grht_pkg::IW-1:0] ram_waddr;
    grht_pkg::t_entry        ram_wdata;
    logic [grht_pkg::IW-1:0] ram_raddr;
    grht_pkg::t_entry        ram_rdata;

    logic out_free;
    logic hit;

    grht_ram #(
        .WIDTH (grht_pkg::ENTRY_W),
        .DEPTH (grht_pkg::SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The output register can take a new result when it is empty or when its
    // current result leaves in this cycle.
    assign out_free = !r_out_valid || !i_stall;

    // A handle names a live slot when the slot holds a token and the stored
    // generation matches. A free slot has a zero token, and a live slot never
    // has generation zero, so a zero handle never matches.
    assign hit = (ram_rdata.tok != '0) && (ram_rdata.gen == r_h);

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_rd_v       = r_rd_v;
        n_rd_idx     = r_rd_idx;
        n_req        = r_req;
        n_h          = r_h;
        n_tok        = r_tok;
        n_idx        = r_idx;
        n_dup        = r_dup;
        n_found      = r_found;
        n_gen        = r_gen;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_data   = r_res_data;
        n_res_freed  = r_res_freed;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_data   = r_out_data;
        n_out_freed  = r_out_freed;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_addr[grht_pkg::IW-1:0];

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                // Zero one slot per cycle after reset.
                ram_we    = 1'b1;
                ram_waddr = r_addr[grht_pkg::IW-1:0];
                if (r_addr == grht_pkg::CW'(grht_pkg::SLOTS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + grht_pkg::CW'(1);
                end
            end

            S_IDLE: begin
                // Start the slot read for acquire and release right away.
                ram_raddr = i_handle_in[grht_pkg::IW-1:0];
                if (i_valid) begin
                    n_req        = i_req_type;
                    n_h          = i_handle_in[63:32];
                    n_tok        = i_data_token;
                    n_idx        = i_handle_in[grht_pkg::IW-1:0];
                    n_addr       = '0;
                    n_rd_v       = 1'b0;
                    n_dup        = 1'b0;
                    n_found      = 1'b0;
                    n_res_status = grht_pkg::ST_OK;
                    n_res_handle = '0;
                    n_res_data   = '0;
                    n_res_freed  = 1'b0;
                    case (i_req_type)
                        grht_pkg::REQ_WRAP: begin
                            if (i_data_token == '0) begin
                                n_res_status = grht_pkg::ST_INVALID_PARAM;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        grht_pkg::REQ_ACQUIRE, grht_pkg::REQ_RELEASE: begin
                            if (i_handle_in[31:0] >= 32'(grht_pkg::SLOTS)) begin
                                n_res_status = grht_pkg::ST_INVALID_PARAM;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_EVAL;
                            end
                        end
                        default: begin
                            n_res_status = grht_pkg::ST_INVALID_PARAM;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end

            S_EVAL: begin
                // Slot data is valid now; check it and write the slot back.
                n_state = S_DONE;
                if (!hit) begin
                    n_res_status = grht_pkg::ST_INVALID_PARAM;
                end else if (r_req == grht_pkg::REQ_ACQUIRE) begin
                    if (ram_rdata.refs == '0) begin
                        n_res_status = grht_pkg::ST_INVALID_STATE;
                    end else if (ram_rdata.refs == grht_pkg::REFS_MAX) begin
                        n_res_status = grht_pkg::ST_OVERFLOW;
                    end else begin
                        ram_we         = 1'b1;
                        ram_wdata      = ram_rdata;
                        ram_wdata.refs = ram_rdata.refs + grht_pkg::REF_W'(1);
                        n_res_data     = ram_rdata.tok;
                    end
                end else begin
                    if (ram_rdata.refs == '0) begin
                        // Double release: the slot is freed without a token.
                        ram_we       = 1'b1;
                        n_res_status = grht_pkg::ST_INVALID_STATE;
                    end else if (ram_rdata.refs == grht_pkg::REF_W'(1)) begin
                        ram_we      = 1'b1;
                        n_res_data  = ram_rdata.tok;
                        n_res_freed = 1'b1;
                    end else begin
                        ram_we         = 1'b1;
                        ram_wdata      = ram_rdata;
                        ram_wdata.refs = ram_rdata.refs - grht_pkg::REF_W'(1);
                    end
                end
            end

            S_SCAN: begin
                // Issue one read per cycle and check its data in the cycle after.
                if (r_addr != grht_pkg::CW'(grht_pkg::SLOTS)) begin
                    n_rd_v   = 1'b1;
                    n_rd_idx = r_addr[grht_pkg::IW-1:0];
                    n_addr   = r_addr + grht_pkg::CW'(1);
                end else begin
                    n_rd_v = 1'b0;
                end
                if (r_rd_v) begin
                    if (ram_rdata.tok == r_tok) begin
                        n_dup = 1'b1;
                    end
                    if (ram_rdata.tok == '0 && !r_found) begin
                        n_found = 1'b1;
                        n_idx   = r_rd_idx;
                    end
                end else if (r_addr == grht_pkg::CW'(grht_pkg::SLOTS)) begin
                    n_state = S_WFIN;
                end
            end

            S_WFIN: begin
                n_state = S_DONE;
                if (r_dup) begin
                    n_res_status = grht_pkg::ST_INVALID_PARAM;
                end else if (!r_found) begin
                    n_res_status = grht_pkg::ST_NO_RESOURCES;
                end else begin
                    ram_we         = 1'b1;
                    ram_wdata.tok  = r_tok;
                    ram_wdata.gen  = r_gen;
                    ram_wdata.refs = grht_pkg::REF_W'(1);
                    n_res_handle   = {r_gen, 32'(r_idx)};
                    // Generations skip zero on wrap-around.
                    if (r_gen == grht_pkg::GEN_MAX) begin
                        n_gen = grht_pkg::GEN_INIT;
                    end else begin
                        n_gen = r_gen + grht_pkg::GEN_W'(1);
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_out_data   = r_res_data;
                    n_out_freed  = r_res_freed;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_rd_v      <= 1'b0;
            r_gen       <= grht_pkg::GEN_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_rd_v      <= n_rd_v;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
        r_rd_idx     <= n_rd_idx;
        r_req        <= n_req;
        r_h          <= n_h;
        r_tok        <= n_tok;
        r_idx        <= n_idx;
        r_dup        <= n_dup;
        r_found      <= n_found;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_data   <= n_res_data;
        r_res_freed  <= n_res_freed;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_data   <= n_out_data;
        r_out_freed  <= n_out_freed;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_handle_out = r_out_handle;
    assign o_data_out   = r_out_data;
    assign o_freed      = r_out_freed;

`ifndef SYNTH
    // No result can appear while the table is still being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid)
        else $error("result presented during the clearing pass");

    // The generation register never holds zero.
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("next generation is zero");

    // The sweep address never runs past the table.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= grht_pkg::CW'(grht_pkg::SLOTS)))
        else $error("sweep address beyond the table");

    // A freeing release returns ok with a nonzero token and no handle.
    a_freed_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_freed) |->
            (o_status == grht_pkg::ST_OK && o_data_out != '0 && o_handle_out == '0))
        else $error("freed result is malformed");

    // A result issuing a handle carries a nonzero generation.
    a_handle_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_handle_out != '0) |->
            (o_handle_out[63:32] != '0 && o_status == grht_pkg::ST_OK))
        else $error("issued handle has generation zero");
`endif

endmodule

### src/grht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module grht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [WIDTH-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [WIDTH-1:0]             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sim/tb.sv
// Self-checking testbench for generational_refcount_handle_table_unit.
// Drives wrap, acquire and release requests and checks each result against a handle table kept
// here in step with the block. Depends on grht_pkg and the block's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names the three real requests. The fourth encoding is the one the block
    // must reject without touching the table.
    localparam logic [1:0] REQ_UNDEFINED = 2'd3;

    // A wrap sweeps every slot. The limit assumes every request is a wrap and then leaves
    // a wide margin on top.
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int          RETIRED_KEEP = 64;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] handle;
        logic [63:0] data;
        logic        freed;
    } t_table_answer;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_req_type   = '0;
    logic [63:0] i_handle_in  = '0;
    logic [63:0] i_data_token = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [63:0] o_handle_out;
    logic [63:0] o_data_out;
    logic        o_freed;

    // Our own copy of the handle table. It is updated at the moment a request is accepted,
    // so its state always matches what the block holds once that request is done.
    logic [63:0] mirror_token  [grht_pkg::SLOTS];
    logic [63:0] mirror_handle [grht_pkg::SLOTS];
    logic [31:0] mirror_refs   [grht_pkg::SLOTS];
    logic [31:0] mirror_next_gen;
    int          mirror_used;

    // Live slots drive the choice of good handles and held tokens. Handles of freed slots
    // are kept for a while so that stale handles can be offered later.
    int            live_slots[$];
    logic [63:0]   retired_handles[$];
    t_table_answer awaited_answers[$];

    int unsigned answer_errors = 0;
    int unsigned cycles_run    = 0;
    bit          steady        = 1'b0;

    generational_refcount_handle_table_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_handle_in  (i_handle_in),
        .i_data_token (i_data_token),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_data_out   (o_data_out),
        .o_freed      (o_freed)
    );

    always #4 i_clk = ~i_clk;

    // The result side holds off at random, with odds of about 18 in a hundred, except in the steady stretch.
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 18);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // A slot goes back to the free pool: clear it, drop it from the live list and remember
    // its handle as a stale one.
    function automatic void retire_slot(int slot);
        retired_handles.push_back(mirror_handle[slot]);
        if (retired_handles.size() > RETIRED_KEEP) begin
            void'(retired_handles.pop_front());
        end
        mirror_token[slot]  = '0;
        mirror_handle[slot] = '0;
        mirror_refs[slot]   = '0;
        if (mirror_used > 0) begin
            mirror_used--;
        end
        for (int k = 0; k < live_slots.size(); k++) begin
            if (live_slots[k] == slot) begin
                live_slots.delete(k);
                break;
            end
        end
    endfunction

    // Works out the answer to one accepted request and applies its effect to the table copy.
    function automatic t_table_answer predict_answer(logic [1:0] req, logic [63:0] h,
                                                     logic [63:0] tok);
        t_table_answer ans;
        int            slot;
        bit            held;
        ans.status = grht_pkg::ST_OK;
        ans.handle = '0;
        ans.data   = '0;
        ans.freed  = 1'b0;
        slot       = -1;
        held       = 1'b0;
        if (req == grht_pkg::REQ_WRAP) begin
            if (tok == '0) begin
                ans.status = grht_pkg::ST_INVALID_PARAM;
            end else begin
                // A held token is rejected even when the table is full as well.
                for (int k = 0; k < grht_pkg::SLOTS; k++) begin
                    if (mirror_token[k] == tok) held = 1'b1;
                    if (slot < 0 && mirror_token[k] == '0) slot = k;
                end
                if (held) begin
                    ans.status = grht_pkg::ST_INVALID_PARAM;
                end else if (slot < 0) begin
                    ans.status = grht_pkg::ST_NO_RESOURCES;
                end else begin
                    ans.handle = {mirror_next_gen, 32'(slot)};
                    // Generations skip zero when they wrap around.
                    mirror_next_gen = (mirror_next_gen == grht_pkg::GEN_MAX)
                                      ? grht_pkg::GEN_INIT : mirror_next_gen + 1'b1;
                    mirror_handle[slot] = ans.handle;
                    mirror_token[slot]  = tok;
                    mirror_refs[slot]   = 32'd1;
                    mirror_used++;
                    live_slots.push_back(slot);
                end
            end
        end else if (req == grht_pkg::REQ_ACQUIRE || req == grht_pkg::REQ_RELEASE) begin
            // A handle is good only if it is nonzero, in range, equal to the stored handle
            // and names an occupied slot.
            if (h != '0 && h[31:0] < grht_pkg::SLOTS) begin
                if (mirror_handle[h[31:0]] == h && mirror_token[h[31:0]] != '0) begin
                    slot = int'(h[31:0]);
                end
            end
            if (slot < 0) begin
                ans.status = grht_pkg::ST_INVALID_PARAM;
            end else if (req == grht_pkg::REQ_ACQUIRE) begin
                if (mirror_refs[slot] == '0) begin
                    ans.status = grht_pkg::ST_INVALID_STATE;
                end else if (mirror_refs[slot] == grht_pkg::REFS_MAX) begin
                    ans.status = grht_pkg::ST_OVERFLOW;
                end else begin
                    mirror_refs[slot]++;
                    ans.data = mirror_token[slot];
                end
            end else if (mirror_refs[slot] == '0) begin
                // Releasing a live slot that has no references left frees it but is an error.
                ans.status = grht_pkg::ST_INVALID_STATE;
                retire_slot(slot);
            end else begin
                mirror_refs[slot]--;
                if (mirror_refs[slot] == '0) begin
                    ans.data  = mirror_token[slot];
                    ans.freed = 1'b1;
                    retire_slot(slot);
                end
            end
        end else begin
            ans.status = grht_pkg::ST_INVALID_PARAM;
        end
        return ans;
    endfunction

    // Mostly a live handle; otherwise a stale one or a corrupted one of several kinds.
    function automatic logic [63:0] pick_handle();
        int unsigned roll;
        logic [63:0] h;
        roll = $urandom_range(99);
        if (live_slots.size() != 0) begin
            h = mirror_handle[live_slots[$urandom_range(live_slots.size() - 1)]];
        end else begin
            h = {$urandom, $urandom};
        end
        if (roll < 80) return h;
        if (roll < 88 && retired_handles.size() != 0) begin
            return retired_handles[$urandom_range(retired_handles.size() - 1)];
        end
        case (roll % 4)
            0: return {$urandom, $urandom};
            1: return {h[63:32], 32'($urandom_range(32'hFFFF_FFFF, grht_pkg::SLOTS))};
            2: return h ^ (64'd1 << $urandom_range(63, 32));
            default: return '0;
        endcase
    endfunction

    // Offers one request, holding it steady while the block stalls, and records the answer
    // expected for it once it is accepted. Valid stays high for a following request.
    task automatic send_request(input logic [1:0] req, input logic [63:0] h,
                                input logic [63:0] tok);
        if (!steady && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_handle_in  <= h;
        i_data_token <= tok;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        awaited_answers.push_back(predict_answer(req, h, tok));
    endtask

    // One random request from a weighted mix. Content is random within each kind: wraps
    // carry mostly fresh tokens, sometimes held, zero or single-bit ones.
    task automatic send_mixed(input int wrap_pct, input int acquire_pct, input int release_pct);
        int unsigned roll;
        int unsigned kind;
        logic [63:0] tok;
        roll = $urandom_range(99);
        kind = $urandom_range(99);
        if (roll < wrap_pct) begin
            if (kind < 8 && live_slots.size() != 0) begin
                tok = mirror_token[live_slots[$urandom_range(live_slots.size() - 1)]];
            end else if (kind < 12) begin
                tok = '0;
            end else if (kind < 16) begin
                tok = 64'd1 << $urandom_range(63);
            end else begin
                tok = {$urandom, $urandom};
            end
            send_request(grht_pkg::REQ_WRAP, {$urandom, $urandom}, tok);
        end else if (roll < wrap_pct + acquire_pct) begin
            send_request(grht_pkg::REQ_ACQUIRE, pick_handle(), {$urandom, $urandom});
        end else if (roll < wrap_pct + acquire_pct + release_pct) begin
            send_request(grht_pkg::REQ_RELEASE, pick_handle(), {$urandom, $urandom});
        end else begin
            send_request(REQ_UNDEFINED, pick_handle(), {$urandom, $urandom});
        end
    endtask

    // Drops valid and waits until every outstanding result has been checked.
    task automatic wait_all_answers();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_answers.size() != 0) @(posedge i_clk);
    endtask

    // Short hand-picked sequence: field extremes, every request kind and the error paths
    // that can be reached in a run of this length.
    task automatic test_directed_cases();
        logic [63:0] first_handle;
        logic [63:0] second_handle;
        // Undefined request kind with all ones, then all zeros.
        send_request(REQ_UNDEFINED, '1, '1);
        send_request(REQ_UNDEFINED, '0, '0);
        // A zero token cannot be wrapped.
        send_request(grht_pkg::REQ_WRAP, '1, '0);
        send_request(grht_pkg::REQ_WRAP, '0, '1);
        first_handle = mirror_handle[0];
        send_request(grht_pkg::REQ_WRAP, '1, 64'd1);
        second_handle = mirror_handle[1];
        send_request(grht_pkg::REQ_WRAP, '0, 64'h8000_0000_0000_0000);
        // Wrapping a token that is already held is refused.
        send_request(grht_pkg::REQ_WRAP, '0, '1);
        send_request(grht_pkg::REQ_ACQUIRE, first_handle, '1);
        // Zero handle, index just past the table, all ones and a wrong generation.
        send_request(grht_pkg::REQ_ACQUIRE, '0, '0);
        send_request(grht_pkg::REQ_ACQUIRE, {32'd1, 32'(grht_pkg::SLOTS)}, '0);
        send_request(grht_pkg::REQ_ACQUIRE, '1, '0);
        send_request(grht_pkg::REQ_ACQUIRE, {first_handle[63:32], second_handle[31:0]}, '0);
        // The last reference frees the slot; the old handle is dead afterwards.
        send_request(grht_pkg::REQ_RELEASE, second_handle, '0);
        send_request(grht_pkg::REQ_ACQUIRE, second_handle, '0);
        send_request(grht_pkg::REQ_RELEASE, second_handle, '0);
        // The freed slot is the lowest free one and is reused under a new generation.
        send_request(grht_pkg::REQ_WRAP, '0, 64'd2);
        // Two references: the first release only drops the count, the second frees.
        send_request(grht_pkg::REQ_RELEASE, first_handle, '1);
        send_request(grht_pkg::REQ_RELEASE, first_handle, '1);
        // Handles that point at the never used top slot.
        send_request(grht_pkg::REQ_RELEASE, {32'd0, 32'(grht_pkg::SLOTS - 1)}, '0);
        send_request(grht_pkg::REQ_RELEASE, {32'hFFFF_FFFF, 32'(grht_pkg::SLOTS - 1)}, '0);
        // An undefined request carrying a good handle must leave the slot alone.
        send_request(REQ_UNDEFINED, mirror_handle[1], mirror_token[1]);
        send_request(grht_pkg::REQ_ACQUIRE, mirror_handle[1], '0);
    endtask

    // General traffic on a partly filled table. A stretch in the middle runs without any
    // idling, and once the sender waits for every result before it carries on.
    task automatic test_random_traffic();
        for (int n = 0; n < 600; n++) begin
            steady = (n >= 250 && n < 400);
            if (n == 450) wait_all_answers();
            send_mixed(25, 35, 35);
        end
        steady = 1'b0;
    endtask

    // Fills every slot, then checks the answers on a full table and the reuse of a slot.
    task automatic test_table_full();
        while (mirror_used < grht_pkg::SLOTS) begin
            send_request(grht_pkg::REQ_WRAP, {$urandom, $urandom}, {$urandom, $urandom});
        end
        send_request(grht_pkg::REQ_WRAP, '0, {$urandom, $urandom});
        send_request(grht_pkg::REQ_WRAP, '0, mirror_token[grht_pkg::SLOTS - 1]);
        send_request(grht_pkg::REQ_ACQUIRE, mirror_handle[grht_pkg::SLOTS - 1], '0);
        send_request(grht_pkg::REQ_RELEASE, mirror_handle[grht_pkg::SLOTS / 2], '0);
        send_request(grht_pkg::REQ_WRAP, '0, {$urandom, $urandom});
    endtask

    // Traffic on a nearly full table, weighted toward release so that slots keep opening
    // and wraps keep landing on the lowest free one.
    task automatic test_churn_when_full();
        for (int n = 0; n < 300; n++) begin
            send_mixed(30, 20, 45);
        end
    endtask

    // Every accepted result is matched against the oldest outstanding answer.
    always @(posedge i_clk) begin
        t_table_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_answers.size() == 0) begin
                $display("%0t: result with nothing outstanding, status %0d handle %h data %h",
                         $time, o_status, o_handle_out, o_data_out);
                answer_errors++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, o_status);
                    answer_errors++;
                end
                if (o_handle_out !== want.handle) begin
                    $display("%0t: handle_out expected %h, got %h",
                             $time, want.handle, o_handle_out);
                    answer_errors++;
                end
                if (o_data_out !== want.data) begin
                    $display("%0t: data_out expected %h, got %h", $time, want.data, o_data_out);
                    answer_errors++;
                end
                if (o_freed !== want.freed) begin
                    $display("%0t: freed expected %0d, got %0d", $time, want.freed, o_freed);
                    answer_errors++;
                end
            end
        end
    end

    initial begin
        foreach (mirror_token[k]) begin
            mirror_token[k]  = '0;
            mirror_handle[k] = '0;
            mirror_refs[k]   = '0;
        end
        mirror_next_gen = grht_pkg::GEN_INIT;
        mirror_used     = 0;

        // Reset is held, then released; the block's clearing pass shows up as stall.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_table_full();
        test_churn_when_full();

        // Let everything drain, then give a stray late result time to show up.
        wait_all_answers();
        repeat (grht_pkg::SLOTS + 16) @(posedge i_clk);
        if (answer_errors == 0 && awaited_answers.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
